### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication that must hold at every clock edge out of reset
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen
`define TRD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRD_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/trd_pkg.sv
package trd_pkg;

    localparam int MAX_K_DEF    = 6;
    localparam int POS_BITS_DEF = 32;
    localparam int CODE_W       = 12;
    localparam int CNT_W        = 32;
    localparam int LEN_W        = 16;
    localparam int KCFG_W       = 3;
    localparam int K_W          = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = 2;
    localparam int FIFO_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MOTIF_LENGTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STR_LENGTH = 1'd1;

    localparam logic [KCFG_W-1:0] MOTIF_LENGTH_RST   = 3'd6;
    localparam logic [LEN_W-1:0]  MIN_STR_LENGTH_RST = 16'd12;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH_RD,
        ST_FLUSH,
        ST_PUSH
    } st_t;

    typedef struct packed {
        logic [CNT_W-1:0] strs;
        logic [CNT_W-1:0] units;
        logic [CNT_W-1:0] bases;
        logic [CNT_W-1:0] gaps;
    } totals_t;

    typedef struct packed {
        logic [CNT_W-1:0]  str_start;
        logic [CNT_W-1:0]  unit_count;
        logic [CODE_W-1:0] motif_code;
        logic [CNT_W-1:0]  str_bases;
        logic [CNT_W-1:0]  gap_bases;
        logic              first_for_motif;
        totals_t           tot;
        logic              final_report;
    } res_t;

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W+4:0] b);
        logic [CNT_W+5:0] s;
        s = {6'd0, a} + {1'b0, b};
        sat_add32 = (s[CNT_W+5:CNT_W] != '0) ? '1 : s[CNT_W-1:0];
    endfunction

endpackage

### rtl/core/trd_if.sv
interface trd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] base;
    logic       last_base;
    modport source (output valid, base, last_base, input ready);
    modport sink (input valid, base, last_base, output ready);
endinterface

interface trd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] str_start;
    logic [31:0] unit_count;
    logic [11:0] motif_code;
    logic [31:0] str_bases;
    logic [31:0] gap_bases;
    logic        first_for_motif;
    logic [31:0] motif_str_total;
    logic [31:0] motif_unit_total;
    logic [31:0] motif_base_total;
    logic [31:0] motif_gap_total;
    logic        final_report;
    modport source (output valid, str_start, unit_count, motif_code, str_bases, gap_bases,
                    first_for_motif, motif_str_total, motif_unit_total, motif_base_total,
                    motif_gap_total, final_report, input ready);
    modport sink (input valid, str_start, unit_count, motif_code, str_bases, gap_bases,
                  first_for_motif, motif_str_total, motif_unit_total, motif_base_total,
                  motif_gap_total, final_report, output ready);
endinterface

interface trd_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  reg_index;
    logic [15:0] wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

### rtl/core/tandem_repeat_detector.sv
// Tandem repeat detector. After reset the block sweeps its two motif tables, one entry per
// cycle, over all 2^(2*MAX_K) entries (4096 at the default), and takes no base until the sweep
// ends; configuration writes are taken at any time. A base that completes a k-mer takes two
// steps: one reads the k-mer entry and the stored repeat's motif entry from their tables, one
// updates the k-mer entry and, if the repeat is reported, the motif entry. An earlier base is
// only shifted in, with a flush when it is the last. A last base that completes a k-mer adds a
// re-read and update of the motif entry, and a push step when it gives two results. Results
// wait in a four-entry queue; a base is taken only while the queue has room for two.
`include "assert_macros.svh"

module tandem_repeat_detector
    import trd_pkg::*;
#(
    parameter int MAX_K    = MAX_K_DEF,
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    trd_in_if.sink    in_ch,
    trd_out_if.source out_ch,
    trd_cfg_if.sink   cfg
);

    localparam int IDX_W = 2 * MAX_K;
    localparam int DEPTH = 1 << IDX_W;
    localparam int PW    = POS_BITS;
    localparam int BW    = CNT_W + K_W;
    localparam int WW    = ((PW > BW) ? PW : BW) + 2;
    localparam logic [PW-1:0] POS_MAX = '1;

    typedef struct packed {
        logic          seen;
        logic          running;
        logic [PW-1:0] last_pos;
    } a_ent_t;

    typedef struct packed {
        logic          has_str;
        logic [PW-1:0] last_end;
        totals_t       tot;
    } b_ent_t;

    a_ent_t a_mem [DEPTH];
    b_ent_t b_mem [DEPTH];

    st_t              st_reg, st_next;
    logic [KCFG_W-1:0] motif_length_reg;
    logic [LEN_W-1:0] min_len_reg;
    logic [PW-1:0]    bases_seen_reg;
    logic [IDX_W-1:0] kmer_reg;
    logic [PW-1:0]    i_reg;
    logic             last_reg;
    logic             kv_reg;
    logic [PW-1:0]    rec_start_reg;
    logic [CNT_W-1:0] rec_units_reg;
    logic [IDX_W-1:0] rec_motif_reg;
    logic             rec_valid_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    res_t             pend_reg;
    logic             pend_valid_reg;
    a_ent_t           a_rdata_reg;
    b_ent_t           b_rdata_reg;

    logic [K_W-1:0]   k;
    logic [IDX_W-1:0] mask;
    logic [IDX_W-1:0] kmer_next;
    logic [PW-1:0]    bases_next;
    logic             in_acc;
    logic             room2;

    logic             a_we;
    logic [IDX_W-1:0] a_waddr;
    a_ent_t           a_wdata;
    logic             b_we;
    logic [IDX_W-1:0] b_waddr;
    b_ent_t           b_wdata;

    logic [WW-1:0]    lp_k;
    logic [BW-1:0]    rec_bases;
    logic [WW-1:0]    rec_hi;
    logic             hit;
    logic             overlap;
    logic             new_run;
    logic             extend;

    logic             rep_ok;
    logic             rep_first;
    logic [PW-1:0]    gap;
    logic [WW-1:0]    gap_w;
    logic [CNT_W-1:0] gap32;
    logic [WW-1:0]    end_w;
    logic [PW-1:0]    end_sat;
    logic [WW-1:0]    start_w;
    logic [CNT_W-1:0] bases32;
    totals_t          tot_new;
    res_t             rep_res;

    logic             push_valid;
    res_t             push_data;
    res_t             pop_data;

    // effective motif length and rolling code
    always_comb
    begin
        if (motif_length_reg == '0)
        begin
            k = K_W'(1);
        end
        else if ({1'b0, motif_length_reg} > K_W'(MAX_K))
        begin
            k = K_W'(MAX_K);
        end
        else
        begin
            k = {1'b0, motif_length_reg};
        end
        for (int j = 0; j < IDX_W; j++)
        begin
            mask[j] = (j < 2 * int'(k));
        end
        kmer_next  = ((kmer_reg << 2) | IDX_W'(in_ch.base)) & mask;
        bases_next = (bases_seen_reg != POS_MAX) ? bases_seen_reg + 1'b1 : bases_seen_reg;
    end

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (st_reg == ST_IDLE) && room2;
    assign cfg.ready = 1'b1;

    // run decision for the current k-mer
    always_comb
    begin
        lp_k      = WW'(a_rdata_reg.last_pos) + WW'(k);
        hit       = a_rdata_reg.seen && (lp_k == WW'(i_reg));
        rec_bases = BW'(rec_units_reg) * BW'(k);
        rec_hi    = WW'(rec_start_reg) + WW'(rec_bases);
        overlap   = rec_valid_reg && (lp_k < rec_hi) && (kmer_reg != rec_motif_reg);
        new_run   = hit && !overlap && !a_rdata_reg.running;
        extend    = hit && !overlap && a_rdata_reg.running;
    end

    // report of the stored repeat
    always_comb
    begin
        rep_ok    = rec_valid_reg && (rec_bases >= BW'(min_len_reg));
        rep_first = !b_rdata_reg.has_str;
        gap       = (!rep_first && (rec_start_reg > b_rdata_reg.last_end))
                    ? rec_start_reg - b_rdata_reg.last_end : '0;
        gap_w     = WW'(gap);
        gap32     = (gap_w > WW'({CNT_W{1'b1}})) ? '1 : gap_w[CNT_W-1:0];
        end_w     = WW'(rec_start_reg) + WW'(rec_bases) - WW'(1);
        end_sat   = (end_w > WW'(POS_MAX)) ? POS_MAX : end_w[PW-1:0];
        start_w   = WW'(rec_start_reg);
        bases32   = (rec_bases[BW-1:CNT_W] != '0) ? '1 : rec_bases[CNT_W-1:0];
        tot_new.strs  = sat_add32(b_rdata_reg.tot.strs, (CNT_W+5)'(1));
        tot_new.units = sat_add32(b_rdata_reg.tot.units, (CNT_W+5)'(rec_units_reg));
        tot_new.bases = sat_add32(b_rdata_reg.tot.bases, (CNT_W+5)'(rec_bases));
        tot_new.gaps  = sat_add32(b_rdata_reg.tot.gaps, (CNT_W+5)'(gap32));
        rep_res.str_start       = start_w[CNT_W-1:0];
        rep_res.unit_count      = rec_units_reg;
        rep_res.motif_code      = CODE_W'(rec_motif_reg);
        rep_res.str_bases       = bases32;
        rep_res.gap_bases       = gap32;
        rep_res.first_for_motif = rep_first;
        rep_res.tot             = tot_new;
        rep_res.final_report    = 1'b1;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (bases_next >= PW'(k))
                    begin
                        st_next = ST_EVAL;
                    end
                    else if (in_ch.last_base)
                    begin
                        st_next = ST_FLUSH;
                    end
                end
            end
            ST_EVAL:
            begin
                st_next = last_reg ? ST_FLUSH_RD : ST_IDLE;
            end
            ST_FLUSH_RD:
            begin
                st_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                st_next = (pend_valid_reg && rep_ok) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_CLEAR;
            end
        endcase
    end

    // table writes and result pushes
    always_comb
    begin
        a_we       = 1'b0;
        a_waddr    = kmer_reg;
        a_wdata    = '0;
        b_we       = 1'b0;
        b_waddr    = rec_motif_reg;
        b_wdata    = '0;
        push_valid = 1'b0;
        push_data  = rep_res;
        case (st_reg)
            ST_CLEAR:
            begin
                a_we    = 1'b1;
                a_waddr = clr_addr_reg;
                b_we    = 1'b1;
                b_waddr = clr_addr_reg;
            end
            ST_EVAL:
            begin
                a_we             = 1'b1;
                a_wdata.seen     = 1'b1;
                a_wdata.running  = a_rdata_reg.seen ? (new_run || extend)
                                                    : a_rdata_reg.running;
                a_wdata.last_pos = i_reg;
                if (new_run && rep_ok)
                begin
                    b_we       = 1'b1;
                    b_wdata    = {1'b1, end_sat, tot_new};
                    push_valid = !last_reg;
                end
            end
            ST_FLUSH:
            begin
                if (rep_ok)
                begin
                    b_we    = 1'b1;
                    b_wdata = {1'b1, end_sat, tot_new};
                end
                if (pend_valid_reg)
                begin
                    push_valid             = 1'b1;
                    push_data              = pend_reg;
                    push_data.final_report = !rep_ok;
                end
                else
                begin
                    push_valid = rep_ok;
                end
            end
            ST_PUSH:
            begin
                push_valid = 1'b1;
                push_data  = pend_reg;
            end
            default:
            begin
                a_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= a_mem[kmer_next];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= b_mem[rec_motif_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            i_reg    <= bases_next - PW'(k);
            last_reg <= in_ch.last_base;
        end
        if ((st_reg == ST_EVAL && new_run && rep_ok && last_reg) ||
            (st_reg == ST_FLUSH && rep_ok))
        begin
            pend_reg <= rep_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_CLEAR;
            motif_length_reg <= MOTIF_LENGTH_RST;
            min_len_reg      <= MIN_STR_LENGTH_RST;
            bases_seen_reg   <= '0;
            kmer_reg         <= '0;
            kv_reg           <= 1'b0;
            rec_start_reg    <= '0;
            rec_units_reg    <= '0;
            rec_motif_reg    <= '0;
            rec_valid_reg    <= 1'b0;
            clr_addr_reg     <= '0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.reg_index)
                    REG_MOTIF_LENGTH:   motif_length_reg <= cfg.wdata[KCFG_W-1:0];
                    REG_MIN_STR_LENGTH: min_len_reg      <= cfg.wdata;
                    default:            min_len_reg      <= min_len_reg;
                endcase
            end
            if (st_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (in_acc)
            begin
                kmer_reg       <= kmer_next;
                bases_seen_reg <= bases_next;
                kv_reg         <= (bases_next >= PW'(k));
                pend_valid_reg <= 1'b0;
            end
            if (st_reg == ST_EVAL)
            begin
                if (new_run)
                begin
                    rec_start_reg <= a_rdata_reg.last_pos;
                    rec_units_reg <= CNT_W'(2);
                    rec_motif_reg <= kmer_reg;
                    rec_valid_reg <= 1'b1;
                    pend_valid_reg <= rep_ok && last_reg;
                end
                else if (extend && rec_units_reg != '1)
                begin
                    rec_units_reg <= rec_units_reg + 1'b1;
                end
            end
            if (st_reg == ST_FLUSH)
            begin
                rec_valid_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    trd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .room2      (room2),
        .pop_valid  (out_ch.valid),
        .pop_ready  (out_ch.ready),
        .pop_data   (pop_data)
    );

    assign out_ch.str_start        = pop_data.str_start;
    assign out_ch.unit_count       = pop_data.unit_count;
    assign out_ch.motif_code       = pop_data.motif_code;
    assign out_ch.str_bases        = pop_data.str_bases;
    assign out_ch.gap_bases        = pop_data.gap_bases;
    assign out_ch.first_for_motif  = pop_data.first_for_motif;
    assign out_ch.motif_str_total  = pop_data.tot.strs;
    assign out_ch.motif_unit_total = pop_data.tot.units;
    assign out_ch.motif_base_total = pop_data.tot.bases;
    assign out_ch.motif_gap_total  = pop_data.tot.gaps;
    assign out_ch.final_report     = pop_data.final_report;

    `TRD_ASSERT(a_eval_after_acc, clk, rst_n, (st_reg == ST_EVAL) |-> ($past(in_acc) && kv_reg), "eval without a valid k-mer item")
    `TRD_ASSERT(a_push_after_flush, clk, rst_n, (st_reg == ST_PUSH) |-> $past(st_reg == ST_FLUSH), "second result out of order")
    `TRD_ASSERT(a_no_acc_in_clear, clk, rst_n, (st_reg == ST_CLEAR) |-> !in_ch.ready, "item taken during table sweep")
    `TRD_NEVER(a_pend_idle, clk, rst_n, (st_reg == ST_IDLE) && pend_valid_reg, "held result left behind")

endmodule

### rtl/core/trd_fifo.sv
module trd_fifo
    import trd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  res_t push_data,
    output logic room2,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_data
);

    res_t                  buf_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = buf_reg[rd_ptr_reg];
    assign room2     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + FIFO_CNT_W'(push_valid) - FIFO_CNT_W'(pop);
        end
    end

endmodule
